[rtl/tftpc_pkg.sv]
// shared types and constants for the tftp client transfer control block
`timescale 1ns / 1ps

package tftpc_pkg;

    // event codes carried on the input tuser
    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_PACKET  = 3'd1;
    localparam logic [2:0] ACT_TIMEOUT = 3'd2;
    localparam logic [2:0] ACT_SOURCE  = 3'd3;
    localparam logic [2:0] ACT_FAULT   = 3'd4;

    // frame kinds to send
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_RRQ  = 3'd1;
    localparam logic [2:0] K_WRQ  = 3'd2;
    localparam logic [2:0] K_DATA = 3'd3;
    localparam logic [2:0] K_ACK  = 3'd4;

    // transfer status codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_REMOTE  = 3'd3;
    localparam logic [2:0] ST_FILE    = 3'd4;
    localparam logic [2:0] ST_IDLE    = 3'd5;

    // received opcodes
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    // configuration register indexes
    localparam logic [7:0] CFG_DIRECTION    = 8'd0;
    localparam logic [7:0] CFG_MAX_ATTEMPTS = 8'd1;

    localparam logic [9:0]  HDR_BYTES         = 10'd4;
    localparam logic [16:0] MAX_FRAME_PAYLOAD = 17'd1019;
    localparam logic [3:0]  DEFAULT_ATTEMPTS  = 4'd5;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic [9:0]  src_len;
        logic [9:0]  pkt_len;
        logic [15:0] pkt_number;
        logic [15:0] pkt_opcode;
        logic [2:0]  action;
    } item_t;

    typedef struct packed {
        logic [15:0] remote_error;
        logic [2:0]  status;
        logic [31:0] bytes_total;
        logic [9:0]  deliver_len;
        logic        need_block;
        logic [9:0]  send_len;
        logic [15:0] send_number;
        logic [2:0]  send_kind;
    } result_t;

endpackage

[rtl/tftpc_engine.sv]
// transfer state registers and the per-event decision logic
`timescale 1ns / 1ps

module tftpc_engine #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  tftpc_pkg::item_t    item,
    input  logic                direction,
    input  logic [3:0]          max_attempts,
    output tftpc_pkg::result_t  res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_CONN = 3'd1;
    localparam logic [2:0] PH_SRC  = 3'd2;
    localparam logic [2:0] PH_ACK  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    localparam logic [16:0] BLK = 17'(BLOCK_BYTES);

    logic [2:0]  phase_reg,      phase_next;
    logic [15:0] block_no_reg,   block_no_next;
    logic [3:0]  attempts_reg,   attempts_next;
    logic [2:0]  last_kind_reg,  last_kind_next;
    logic [9:0]  last_len_reg,   last_len_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic        final_reg,      final_next;
    logic [2:0]  status_reg,     status_next;
    logic [15:0] remote_reg,     remote_next;

    always_comb
    begin
        logic        waiting;
        logic        upload;
        logic        do_retry;
        logic        add_en;
        logic [9:0]  add_val;
        logic [32:0] sum;
        logic [3:0]  fresh;
        logic [15:0] expect_no;
        logic [16:0] n17;
        logic [9:0]  pay;
        logic [9:0]  src_n;

        phase_next      = phase_reg;
        block_no_next   = block_no_reg;
        attempts_next   = attempts_reg;
        last_kind_next  = last_kind_reg;
        last_len_next   = last_len_reg;
        byte_count_next = byte_count_reg;
        final_next      = final_reg;
        status_next     = status_reg;
        remote_next     = remote_reg;
        res             = '0;

        waiting   = (phase_reg == PH_CONN) || (phase_reg == PH_ACK) || (phase_reg == PH_DATA);
        upload    = (phase_reg == PH_ACK) || ((phase_reg == PH_CONN) &&
                    (last_kind_reg == tftpc_pkg::K_WRQ));
        do_retry  = 1'b0;
        add_en    = 1'b0;
        add_val   = '0;
        fresh     = (max_attempts == 4'd0) ? 4'd0 : max_attempts - 4'd1;
        expect_no = block_no_reg + 16'd1;

        // received payload, clamped to the block size
        pay = item.pkt_len - tftpc_pkg::HDR_BYTES;
        if ({7'd0, pay} > BLK)
        begin
            pay = BLK[9:0];
        end

        // source block length, clamped to block size and frame limit
        n17 = {7'd0, item.src_len};
        if (n17 > BLK)
        begin
            n17 = BLK;
        end
        if (n17 > tftpc_pkg::MAX_FRAME_PAYLOAD)
        begin
            n17 = tftpc_pkg::MAX_FRAME_PAYLOAD;
        end
        src_n = n17[9:0];

        case (item.action)
            tftpc_pkg::ACT_START:
            begin
                block_no_next   = '0;
                byte_count_next = '0;
                final_next      = 1'b0;
                remote_next     = '0;
                status_next     = tftpc_pkg::ST_BUSY;
                phase_next      = PH_CONN;
                last_kind_next  = direction ? tftpc_pkg::K_RRQ : tftpc_pkg::K_WRQ;
                last_len_next   = '0;
                attempts_next   = fresh;
                res.send_kind   = last_kind_next;
            end
            tftpc_pkg::ACT_PACKET:
            begin
                if (waiting)
                begin
                    if (item.pkt_len < tftpc_pkg::HDR_BYTES)
                    begin
                        do_retry = 1'b1;
                    end
                    else if (item.pkt_opcode == tftpc_pkg::OP_ERROR)
                    begin
                        remote_next = item.pkt_number;
                        phase_next  = PH_DONE;
                        status_next = tftpc_pkg::ST_REMOTE;
                    end
                    else if (upload)
                    begin
                        if ((phase_reg == PH_CONN) && (item.pkt_opcode == tftpc_pkg::OP_ACK) &&
                            (item.pkt_number == 16'd0))
                        begin
                            block_no_next  = 16'd1;
                            phase_next     = PH_SRC;
                            res.need_block = 1'b1;
                        end
                        else if ((phase_reg == PH_ACK) &&
                                 (item.pkt_opcode == tftpc_pkg::OP_ACK) &&
                                 (item.pkt_number == block_no_reg))
                        begin
                            add_en        = 1'b1;
                            add_val       = last_len_reg - tftpc_pkg::HDR_BYTES;
                            block_no_next = expect_no;
                            if (final_reg)
                            begin
                                phase_next  = PH_DONE;
                                status_next = tftpc_pkg::ST_OK;
                            end
                            else
                            begin
                                phase_next     = PH_SRC;
                                res.need_block = 1'b1;
                            end
                        end
                        else
                        begin
                            do_retry = 1'b1;
                        end
                    end
                    else if ((item.pkt_opcode == tftpc_pkg::OP_DATA) &&
                             (item.pkt_number == expect_no))
                    begin
                        res.deliver_len = pay;
                        add_en          = 1'b1;
                        add_val         = pay;
                        block_no_next   = expect_no;
                        res.send_kind   = tftpc_pkg::K_ACK;
                        res.send_number = expect_no;
                        last_kind_next  = tftpc_pkg::K_ACK;
                        last_len_next   = '0;
                        attempts_next   = fresh;
                        // a short block closes the download
                        if ({7'd0, pay} < BLK)
                        begin
                            phase_next  = PH_DONE;
                            status_next = tftpc_pkg::ST_OK;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        do_retry = 1'b1;
                    end
                end
            end
            tftpc_pkg::ACT_TIMEOUT:
            begin
                do_retry = waiting;
            end
            tftpc_pkg::ACT_SOURCE:
            begin
                if (phase_reg == PH_SRC)
                begin
                    final_next      = ({7'd0, src_n} < BLK);
                    last_kind_next  = tftpc_pkg::K_DATA;
                    last_len_next   = src_n + tftpc_pkg::HDR_BYTES;
                    attempts_next   = fresh;
                    phase_next      = PH_ACK;
                    res.send_kind   = tftpc_pkg::K_DATA;
                    res.send_number = block_no_reg;
                    res.send_len    = last_len_next;
                end
            end
            tftpc_pkg::ACT_FAULT:
            begin
                if (waiting || (phase_reg == PH_SRC))
                begin
                    phase_next  = PH_DONE;
                    status_next = tftpc_pkg::ST_FILE;
                end
            end
            default:
            begin
            end
        endcase

        // resend the last frame or give up
        if (do_retry)
        begin
            if (attempts_reg != 4'd0)
            begin
                attempts_next = attempts_reg - 4'd1;
                res.send_kind = last_kind_reg;
                if ((last_kind_reg == tftpc_pkg::K_DATA) || (last_kind_reg == tftpc_pkg::K_ACK))
                begin
                    res.send_number = block_no_reg;
                end
                res.send_len = last_len_reg;
            end
            else
            begin
                phase_next  = PH_DONE;
                status_next = tftpc_pkg::ST_TIMEOUT;
            end
        end

        // saturating byte total
        sum = {1'b0, byte_count_reg} + {23'd0, add_val};
        if (add_en)
        begin
            byte_count_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end

        res.bytes_total  = byte_count_next;
        res.status       = status_next;
        res.remote_error = (status_next == tftpc_pkg::ST_REMOTE) ? remote_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            block_no_reg   <= '0;
            attempts_reg   <= '0;
            last_kind_reg  <= tftpc_pkg::K_NONE;
            last_len_reg   <= '0;
            byte_count_reg <= '0;
            final_reg      <= 1'b0;
            status_reg     <= tftpc_pkg::ST_IDLE;
            remote_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            block_no_reg   <= block_no_next;
            attempts_reg   <= attempts_next;
            last_kind_reg  <= last_kind_next;
            last_len_reg   <= last_len_next;
            byte_count_reg <= byte_count_next;
            final_reg      <= final_next;
            status_reg     <= status_next;
            remote_reg     <= remote_next;
        end
    end

    a_need_goes_src: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.need_block |=> phase_reg == PH_SRC)
        else $error("need_block issued without moving to source wait");

    a_data_has_header: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (res.send_kind == tftpc_pkg::K_DATA) |-> res.send_len >= tftpc_pkg::HDR_BYTES)
        else $error("data frame shorter than its header");

    a_start_connects: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.action == tftpc_pkg::ACT_START) |=>
        (phase_reg == PH_CONN) && (status_reg == tftpc_pkg::ST_BUSY) && (byte_count_reg == 32'd0))
        else $error("start did not open a fresh transfer");

    a_done_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> (status_reg != tftpc_pkg::ST_BUSY) &&
        (status_reg != tftpc_pkg::ST_IDLE))
        else $error("finished transfer without a final status");

endmodule

[rtl/tftp_client_transfer_control.sv]
// top level: stream handshake, config registers, input and result registers
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tuser: action; tdata: opcode, number, lengths
//  m_*     | out | m_tvalid / m_tready | tuser: send_kind; tdata: frame info, status
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (0 direction, 1 attempts)
//
// one event per cycle sustained while m_tready stays high; a result reaches m_* through
// the input register, then the decision logic into the result register
// rst_n clears all control state: status idle, direction upload, five attempts
// m_tready low holds the result register; one more word waits in the input register
// cfg_ready is always high, registers apply on the next edge
`timescale 1ns / 1ps

module tftp_client_transfer_control #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tftpc_pkg::IN_DATA_W-1:0]     s_tdata,   // pkt_opcode, pkt_number, pkt_len, src_len
    input  logic [2:0]                          s_tuser,   // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tftpc_pkg::OUT_DATA_W-1:0]    m_tdata,   // send_number, send_len, need_block,
                                                           // deliver_len, bytes_total, status,
                                                           // remote_error
    output logic [2:0]                          m_tuser,   // send_kind
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [7:0]                          cfg_index,
    input  logic [7:0]                          cfg_data
);

    logic                in_valid_reg;
    tftpc_pkg::item_t    in_item_reg;
    logic                out_valid_reg;
    tftpc_pkg::result_t  out_res_reg;
    tftpc_pkg::result_t  res;
    logic                direction_reg;
    logic [3:0]          max_attempts_reg;
    logic                advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.action     <= s_tuser;
            in_item_reg.pkt_opcode <= s_tdata[15:0];
            in_item_reg.pkt_number <= s_tdata[31:16];
            in_item_reg.pkt_len    <= s_tdata[41:32];
            in_item_reg.src_len    <= s_tdata[51:42];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= 1'b0;
            max_attempts_reg <= tftpc_pkg::DEFAULT_ATTEMPTS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tftpc_pkg::CFG_DIRECTION)
            begin
                direction_reg <= cfg_data[0];
            end
            else if (cfg_index == tftpc_pkg::CFG_MAX_ATTEMPTS)
            begin
                max_attempts_reg <= cfg_data[3:0];
            end
        end
    end

    tftpc_engine #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .item         (in_item_reg),
        .direction    (direction_reg),
        .max_attempts (max_attempts_reg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.send_kind;
    assign m_tdata  = {out_res_reg.remote_error, out_res_reg.status, out_res_reg.bytes_total,
                       out_res_reg.deliver_len, out_res_reg.need_block, out_res_reg.send_len,
                       out_res_reg.send_number};

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending event word dropped or changed");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed event produced no result word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !advance)
        else $error("result word overwritten while stalled");

endmodule

[bench/testbench.sv]
// self-checking bench for the tftp client transfer control block
`timescale 1ns / 1ps

module testbench;
    import tftpc_pkg::*;

    localparam int BLOCK      = 512;
    localparam int IDLE_LIMIT = 5000;

    typedef enum logic [2:0] {
        XF_IDLE, XF_CONNECT, XF_SOURCE, XF_WAIT_ACK, XF_WAIT_DATA, XF_DONE
    } xfer_phase_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] opcode;
        logic [15:0] number;
        logic [9:0]  plen;
        logic [9:0]  slen;
    } tftp_event_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] number;
        logic [9:0]  len;
        logic        need;
        logic [9:0]  deliver;
        logic [31:0] total;
        logic [2:0]  status;
        logic [15:0] rerr;
    } frame_plan_t;

    typedef struct {
        bit          is_cfg;
        logic [7:0]  cfg_idx;
        logic [7:0]  cfg_val;
        tftp_event_t ev;
        bit          typed;
        frame_plan_t want;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [7:0]            cfg_index = '0;
    logic [7:0]            cfg_data = '0;

    tftp_client_transfer_control u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // predicted transfer state and register copies
    logic        dir_cfg    = 1'b0;
    logic [3:0]  tries_cfg  = DEFAULT_ATTEMPTS;
    xfer_phase_t xphase     = XF_IDLE;
    logic [15:0] blk        = '0;
    logic [3:0]  tries_left = '0;
    logic [2:0]  last_kind  = K_NONE;
    logic [9:0]  last_len   = '0;
    logic [31:0] total      = '0;
    logic        final_blk  = 1'b0;
    logic [2:0]  xstatus    = ST_IDLE;
    logic [15:0] err_code   = '0;

    frame_plan_t planned_frames[$];
    script_row_t script[$];

    int gap_pct       = 0;
    int stall_pct     = 0;
    int fails         = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int ends[8];
    int idle_cycles   = 0;

    function automatic logic [3:0] fresh_tries();
        return (tries_cfg == 4'd0) ? 4'd0 : tries_cfg - 4'd1;
    endfunction

    function automatic void add_total(input logic [31:0] n);
        logic [32:0] s;
        s = {1'b0, total} + {1'b0, n};
        total = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void end_transfer(input logic [2:0] st);
        xphase  = XF_DONE;
        xstatus = st;
        ends[st]++;
    endfunction

    // resend the last frame while attempts remain, else give up
    function automatic void resend(inout frame_plan_t r);
        if (tries_left != 4'd0)
        begin
            tries_left = tries_left - 4'd1;
            r.kind     = last_kind;
            r.number   = (last_kind == K_DATA || last_kind == K_ACK) ? blk : 16'd0;
            r.len      = last_len;
        end
        else
            end_transfer(ST_TIMEOUT);
    endfunction

    function automatic frame_plan_t plan_response(input tftp_event_t ev);
        frame_plan_t r;
        logic        waiting;
        logic        upload;
        logic [9:0]  pay;
        logic [9:0]  n;
        logic [15:0] nxt;
        r = '0;
        waiting = (xphase == XF_CONNECT || xphase == XF_WAIT_ACK || xphase == XF_WAIT_DATA);
        case (ev.action)
            ACT_START:
            begin
                blk        = '0;
                total      = '0;
                final_blk  = 1'b0;
                err_code   = '0;
                xstatus    = ST_BUSY;
                xphase     = XF_CONNECT;
                last_kind  = dir_cfg ? K_RRQ : K_WRQ;
                last_len   = '0;
                tries_left = fresh_tries();
                r.kind     = last_kind;
            end
            ACT_PACKET:
            begin
                if (waiting)
                begin
                    upload = (xphase == XF_WAIT_ACK) ||
                             (xphase == XF_CONNECT && last_kind == K_WRQ);
                    if (ev.plen < HDR_BYTES)
                        resend(r);
                    else if (ev.opcode == OP_ERROR)
                    begin
                        err_code = ev.number;
                        end_transfer(ST_REMOTE);
                    end
                    else if (upload)
                    begin
                        if (xphase == XF_CONNECT && ev.opcode == OP_ACK && ev.number == 16'd0)
                        begin
                            blk    = 16'd1;
                            xphase = XF_SOURCE;
                            r.need = 1'b1;
                        end
                        else if (xphase == XF_WAIT_ACK && ev.opcode == OP_ACK &&
                                 ev.number == blk)
                        begin
                            add_total(32'(last_len) - 32'(HDR_BYTES));
                            blk = blk + 16'd1;
                            if (final_blk)
                                end_transfer(ST_OK);
                            else
                            begin
                                xphase = XF_SOURCE;
                                r.need = 1'b1;
                            end
                        end
                        else
                            resend(r);
                    end
                    else
                    begin
                        nxt = blk + 16'd1;
                        if (ev.opcode == OP_DATA && ev.number == nxt)
                        begin
                            pay = ev.plen - HDR_BYTES;
                            if (pay > BLOCK)
                                pay = 10'(BLOCK);
                            r.deliver  = pay;
                            add_total(32'(pay));
                            blk        = nxt;
                            r.kind     = K_ACK;
                            r.number   = blk;
                            last_kind  = K_ACK;
                            last_len   = '0;
                            tries_left = fresh_tries();
                            if (pay < BLOCK)
                                end_transfer(ST_OK);
                            else
                                xphase = XF_WAIT_DATA;
                        end
                        else
                            resend(r);
                    end
                end
            end
            ACT_TIMEOUT:
            begin
                if (waiting)
                    resend(r);
            end
            ACT_SOURCE:
            begin
                if (xphase == XF_SOURCE)
                begin
                    n = ev.slen;
                    if (n > BLOCK)
                        n = 10'(BLOCK);
                    final_blk  = (n < BLOCK);
                    last_kind  = K_DATA;
                    last_len   = n + HDR_BYTES;
                    tries_left = fresh_tries();
                    xphase     = XF_WAIT_ACK;
                    r.kind     = K_DATA;
                    r.number   = blk;
                    r.len      = last_len;
                end
            end
            ACT_FAULT:
            begin
                if (waiting || xphase == XF_SOURCE)
                    end_transfer(ST_FILE);
            end
            default: ;
        endcase
        r.total  = total;
        r.status = xstatus;
        r.rerr   = (xstatus == ST_REMOTE) ? err_code : 16'd0;
        return r;
    endfunction

    // mostly the word the current state waits for, with random content elsewhere
    function automatic tftp_event_t pick_event();
        tftp_event_t ev;
        int          roll;
        ev.action = ACT_PACKET;
        ev.opcode = 16'($urandom);
        ev.number = 16'($urandom);
        ev.plen   = 10'($urandom);
        ev.slen   = 10'($urandom);
        roll = $urandom_range(99);
        if (xphase == XF_IDLE || xphase == XF_DONE)
            ev.action = (roll < 85) ? ACT_START : 3'($urandom_range(7));
        else if (roll < 85)
        begin
            case (xphase)
                XF_CONNECT:
                begin
                    ev.opcode = (last_kind == K_WRQ) ? OP_ACK : OP_DATA;
                    ev.number = (last_kind == K_WRQ) ? 16'd0 : blk + 16'd1;
                    ev.plen   = ($urandom_range(2) != 0) ? 10'(BLOCK + 4)
                                                         : 10'($urandom_range(4, 1023));
                end
                XF_SOURCE:
                begin
                    ev.action = ACT_SOURCE;
                    ev.slen   = ($urandom_range(3) != 0) ? 10'(BLOCK)
                                                         : 10'($urandom_range(1023));
                end
                XF_WAIT_ACK:
                begin
                    ev.opcode = OP_ACK;
                    ev.number = blk;
                    ev.plen   = 10'($urandom_range(4, 1023));
                end
                default:
                begin
                    ev.opcode = OP_DATA;
                    ev.number = blk + 16'd1;
                    ev.plen   = ($urandom_range(3) != 0) ? 10'(BLOCK + 4)
                                                         : 10'($urandom_range(4, 1023));
                end
            endcase
        end
        else
        begin
            case ($urandom_range(9))
                0, 1: ev.action = ACT_TIMEOUT;
                2, 3: ev.plen = 10'($urandom_range(3));
                4, 5: ;
                6:
                begin
                    if ($urandom_range(2) == 0)
                        ev.opcode = OP_ERROR;
                    else
                        ev.action = ACT_SOURCE;
                end
                7: ev.action = ($urandom_range(3) == 0) ? ACT_FAULT : 3'($urandom_range(5, 7));
                8: ev.action = ACT_START;
                default: ev.action = 3'($urandom_range(7));
            endcase
        end
        return ev;
    endfunction

    function automatic tftp_event_t mk_event(input logic [2:0] act, input logic [15:0] op,
                                             input logic [15:0] num, input logic [9:0] plen,
                                             input logic [9:0] slen);
        tftp_event_t ev;
        ev.action = act;
        ev.opcode = op;
        ev.number = num;
        ev.plen   = plen;
        ev.slen   = slen;
        return ev;
    endfunction

    function automatic void add_ev(input logic [2:0] act, input logic [15:0] op,
                                   input logic [15:0] num, input logic [9:0] plen,
                                   input logic [9:0] slen);
        script_row_t row;
        row.is_cfg  = 1'b0;
        row.cfg_idx = '0;
        row.cfg_val = '0;
        row.ev      = mk_event(act, op, num, plen, slen);
        row.typed   = 1'b0;
        row.want    = '0;
        script.push_back(row);
    endfunction

    // row whose result is written out by hand: only kind, total, status, error code
    function automatic void add_typed(input logic [2:0] act, input logic [15:0] op,
                                      input logic [15:0] num, input logic [9:0] plen,
                                      input logic [2:0] kind, input logic [31:0] tot,
                                      input logic [2:0] st, input logic [15:0] rerr);
        script_row_t row;
        row.is_cfg      = 1'b0;
        row.cfg_idx     = '0;
        row.cfg_val     = '0;
        row.ev          = mk_event(act, op, num, plen, 10'd0);
        row.typed       = 1'b1;
        row.want        = '0;
        row.want.kind   = kind;
        row.want.total  = tot;
        row.want.status = st;
        row.want.rerr   = rerr;
        script.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [7:0] idx, input logic [7:0] val);
        script_row_t row;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.ev      = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        script.push_back(row);
    endfunction

    function automatic void build_script();
        // nothing running yet: everything is ignored
        add_typed(ACT_PACKET, OP_ACK, 16'd0, 10'd4, K_NONE, 32'd0, ST_IDLE, 16'd0);
        add_typed(ACT_TIMEOUT, 16'd0, 16'd0, 10'd0, K_NONE, 32'd0, ST_IDLE, 16'd0);
        add_typed(ACT_FAULT, 16'd0, 16'd0, 10'd0, K_NONE, 32'd0, ST_IDLE, 16'd0);
        add_typed(3'd7, 16'hFFFF, 16'hFFFF, 10'h3FF, K_NONE, 32'd0, ST_IDLE, 16'd0);
        // upload: oversized block, final empty block, every kind of retry
        add_typed(ACT_START, 16'd0, 16'd0, 10'd0, K_WRQ, 32'd0, ST_BUSY, 16'd0);
        add_ev(ACT_PACKET, OP_ACK, 16'd0, 10'd4, 10'd0);
        add_ev(ACT_SOURCE, 16'd0, 16'd0, 10'd0, 10'h3FF);
        add_ev(ACT_PACKET, OP_ACK, 16'd1, 10'h3FF, 10'd0);
        add_ev(ACT_SOURCE, 16'd0, 16'd0, 10'd0, 10'd0);
        add_ev(ACT_PACKET, OP_ACK, 16'd2, 10'd0, 10'd0);
        add_ev(ACT_PACKET, 16'hFFFF, 16'd2, 10'd4, 10'd0);
        add_ev(ACT_TIMEOUT, 16'd0, 16'd0, 10'd0, 10'd0);
        add_ev(ACT_PACKET, OP_ACK, 16'hFFFF, 10'd4, 10'd0);
        add_ev(ACT_PACKET, OP_ACK, 16'd2, 10'd516, 10'd0);
        add_ev(ACT_FAULT, 16'd0, 16'd0, 10'd0, 10'd0);
        // download with zero attempts behaves as one attempt
        add_cfg(CFG_DIRECTION, 8'd1);
        add_cfg(CFG_MAX_ATTEMPTS, 8'd0);
        add_typed(ACT_START, 16'd0, 16'd0, 10'd0, K_RRQ, 32'd0, ST_BUSY, 16'd0);
        add_typed(ACT_TIMEOUT, 16'd0, 16'd0, 10'd0, K_NONE, 32'd0, ST_TIMEOUT, 16'd0);
        add_cfg(CFG_MAX_ATTEMPTS, 8'd15);
        add_ev(ACT_START, 16'd0, 16'd0, 10'd0, 10'd0);
        add_ev(ACT_PACKET, OP_DATA, 16'd1, 10'd516, 10'd0);
        // direction flips mid transfer but only counts at the next start
        add_cfg(CFG_DIRECTION, 8'd0);
        add_ev(ACT_PACKET, OP_DATA, 16'd2, 10'h3FF, 10'd0);
        add_ev(ACT_PACKET, OP_DATA, 16'd7, 10'd516, 10'd0);
        add_ev(ACT_PACKET, OP_DATA, 16'd3, 10'd4, 10'd0);
        add_typed(ACT_START, 16'd0, 16'd0, 10'd0, K_WRQ, 32'd0, ST_BUSY, 16'd0);
        add_typed(ACT_PACKET, OP_ERROR, 16'hFFFF, 10'd4, K_NONE, 32'd0, ST_REMOTE, 16'hFFFF);
        add_typed(ACT_START, 16'd0, 16'd0, 10'd0, K_WRQ, 32'd0, ST_BUSY, 16'd0);
        add_typed(ACT_FAULT, 16'd0, 16'd0, 10'd0, K_NONE, 32'd0, ST_FILE, 16'd0);
    endfunction

    task automatic send_event(input tftp_event_t ev, input bit use_typed,
                              input frame_plan_t typed_want);
        frame_plan_t p;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, ev.slen, ev.plen, ev.number, ev.opcode};
        s_tuser  <= ev.action;
        do @(posedge clk); while (!s_tready);
        p = plan_response(ev);
        planned_frames.push_back(use_typed ? typed_want : p);
        items_sent++;
    endtask

    // hold the sender until every planned frame has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (planned_frames.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DIRECTION)
            dir_cfg = val[0];
        else if (idx == CFG_MAX_ATTEMPTS)
            tries_cfg = val[3:0];
    endtask

    task automatic random_reg_write();
        logic [7:0] idx;
        logic [7:0] val;
        int         roll;
        roll = $urandom_range(9);
        val  = 8'($urandom);
        if (roll < 4)
            idx = CFG_DIRECTION;
        else if (roll < 9)
        begin
            idx = CFG_MAX_ATTEMPTS;
            case ($urandom_range(4))
                0: val[3:0] = 4'd0;
                1: val[3:0] = 4'd1;
                2: val[3:0] = 4'd15;
                default: ;
            endcase
        end
        else
            idx = 8'($urandom_range(2, 255));
        write_reg(idx, val);
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        frame_plan_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (planned_frames.size() == 0)
            begin
                $error("send_kind: expected no word, got %0d", m_tuser);
                fails++;
            end
            else
            begin
                want = planned_frames.pop_front();
                check_field("send_kind", 32'(want.kind), 32'(m_tuser));
                check_field("send_number", 32'(want.number), 32'(m_tdata[15:0]));
                check_field("send_len", 32'(want.len), 32'(m_tdata[25:16]));
                check_field("need_block", 32'(want.need), 32'(m_tdata[26]));
                check_field("deliver_len", 32'(want.deliver), 32'(m_tdata[36:27]));
                check_field("bytes_total", want.total, m_tdata[68:37]);
                check_field("status", 32'(want.status), 32'(m_tdata[71:69]));
                check_field("remote_error", 32'(want.rerr), 32'(m_tdata[87:72]));
                words_checked++;
            end
        end
    end

    // ends the run when no channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int gaps[4];
        int stalls[4];
        int target;
        gaps   = '{0, 52, 0, 8};
        stalls = '{0, 0, 52, 8};
        foreach (ends[i])
            ends[i] = 0;
        build_script();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            else
                send_event(script[i].ev, script[i].typed, script[i].want);
        end
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            gap_pct   = gaps[ph];
            stall_pct = stalls[ph];
            target    = items_sent + 335;
            while (items_sent < target)
            begin
                if ((xphase == XF_DONE || xphase == XF_IDLE) && $urandom_range(3) == 0)
                    random_reg_write();
                send_event(pick_event(), 1'b0, '0);
            end
        end
        drain();
        repeat (8) @(posedge clk);
        $display("ran %0d events (directed, then random under four idle mixes), %0d words checked",
                 items_sent, words_checked);
        $display("transfers ended: %0d ok, %0d timeout, %0d remote error, %0d file fault",
                 ends[ST_OK], ends[ST_TIMEOUT], ends[ST_REMOTE], ends[ST_FILE]);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/tftpc_pkg.sv
rtl/tftpc_engine.sv
rtl/tftp_client_transfer_control.sv
bench/testbench.sv
